// ===== hdl/rtc_time_of_day_keeper_assert.svh =====
// ----------------------------------------------------------------------------
// rtc time-of-day keeper assertion macros
// shared property forms, clocked on clk and quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RTC_TIME_OF_DAY_KEEPER_ASSERT_SVH
`define RTC_TIME_OF_DAY_KEEPER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define RTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define RTC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rtc_tod_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc time-of-day keeper package
// widths, reset values, command codes and controller/datapath link types
// ----------------------------------------------------------------------------
package rtc_tod_pkg;

    localparam int COUNTS_PER_SECOND = 32768;
    localparam int COUNTER_BITS      = 24;
    localparam int CPS_LOG2          = $clog2(COUNTS_PER_SECOND);
    localparam int FRAC_BITS         = 8;
    localparam int FRAC_LSB          = CPS_LOG2 - FRAC_BITS;
    localparam int SECS_W            = COUNTER_BITS - CPS_LOG2;
    localparam int SECONDS_W         = 32;
    localparam int TIME_W            = 64;
    localparam int TIME_PAD_W        = TIME_W - SECONDS_W - FRAC_BITS;
    localparam int COUNTER_FIELD_W   = 24;
    localparam int COMPARE_W         = 24;
    localparam int TICK_W            = 16;
    localparam int HIB_W             = 9;
    localparam int MATCH_W           = COUNTER_BITS + 1;
    localparam int DIV_CNT_W         = $clog2(MATCH_W);
    localparam int CMD_W             = 2;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 16;

    localparam logic [TICK_W-1:0] TICK_RESET      = TICK_W'(2048);
    localparam logic [HIB_W-1:0]  HIB_MAX_RESET   = HIB_W'(256);
    localparam int                EIGHT_HOURS_SECS = 8 * 60 * 60;
    localparam logic [TIME_W-1:0] OFFSET_RESET    =
        TIME_W'(EIGHT_HOURS_SECS) << SECONDS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_SET_TIME  = 2'd1,
        CMD_HIBERNATE = 2'd2,
        CMD_CONVERT   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_INCREMENT = 1'b0,
        CFG_HIBERNATE_MAX  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic compare;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic sample;
    } dp_status_t;

endpackage

// ===== hdl/rtc_tod_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtc time-of-day keeper controller
// sequences load, execute, remainder iterations, compare and result hand-off
// ----------------------------------------------------------------------------
`include "rtc_time_of_day_keeper_assert.svh"

module rtc_tod_ctrl
    import rtc_tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_COMPARE,
        S_PUBLISH
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   div_count_reg;
    logic [DIV_CNT_W-1:0]   div_count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load       = (state_reg == S_IDLE) && in_valid;
        cmd.exec       = (state_reg == S_EXEC);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.compare    = (state_reg == S_COMPARE);
        cmd.publish    = (state_reg == S_PUBLISH) && out_free;

        state_next     = state_reg;
        div_count_next = div_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                div_count_next = DIV_CNT_W'(MATCH_W - 1);
                state_next     = status.sample ? S_DIV : S_PUBLISH;
            end
            S_DIV:
            begin
                if (div_count_reg == '0)
                begin
                    state_next = S_COMPARE;
                end
                else
                begin
                    div_count_next = div_count_reg - 1'b1;
                end
            end
            S_COMPARE:
            begin
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_count_reg <= div_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RTC_ASSERT_NXT(a_accept_exec, in_valid && !in_stall, state_reg == S_EXEC, "accepted word did not start execution")
    `RTC_ASSERT_NXT(a_div_end, (state_reg == S_DIV) && (div_count_reg == '0), state_reg == S_COMPARE, "remainder loop overran")
    `RTC_ASSERT_NXT(a_short_cmd, (state_reg == S_EXEC) && !status.sample, state_reg == S_PUBLISH, "non-sample command entered remainder loop")
    `RTC_ASSERT_NXT(a_publish_done, cmd.publish, out_valid_reg && (state_reg == S_IDLE), "published word not presented")

endmodule

// ===== hdl/rtc_tod_datapath.sv =====
// ----------------------------------------------------------------------------
// rtc time-of-day keeper datapath
// time state, wall offset, wake target, remainder unit and result register
// ----------------------------------------------------------------------------
module rtc_tod_datapath
    import rtc_tod_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic [CMD_W-1:0]           command,
    input  logic [COUNTER_FIELD_W-1:0] counter,
    input  logic [TIME_W-1:0]          new_time,
    input  logic [SECONDS_W-1:0]       wake_at,
    input  logic [SECONDS_W-1:0]       wall_seconds,
    output logic [SECONDS_W-1:0]       seconds_since_boot,
    output logic [FRAC_BITS-1:0]       second_fraction,
    output logic [COMPARE_W-1:0]       compare_value,
    output logic [TIME_W-1:0]          time_of_day,
    output logic [SECONDS_W-1:0]       converted_seconds,
    output logic                       time_set
);

    // configuration
    logic [TICK_W-1:0]          tick_reg;
    logic [HIB_W-1:0]           hib_max_reg;

    // time state
    logic [SECONDS_W-1:0]       wrap_count_reg;
    logic [SECS_W-1:0]          last_secs_reg;
    logic [SECONDS_W-1:0]       boot_seconds_reg;
    logic [FRAC_BITS-1:0]       boot_fraction_reg;
    logic [TIME_W-1:0]          offset_reg;
    logic [SECONDS_W-1:0]       wake_target_reg;

    // latched word and work registers
    cmd_t                       cmd_reg;
    logic [COUNTER_BITS-1:0]    cntr_reg;
    logic [TIME_W-1:0]          new_time_reg;
    logic [SECONDS_W-1:0]       wake_at_reg;
    logic [SECONDS_W-1:0]       wall_reg;
    logic [MATCH_W-1:0]         match_reg;
    logic [MATCH_W-1:0]         shift_reg;
    logic [TICK_W-1:0]          rem_reg;
    logic [COUNTER_BITS-1:0]    compare_reg;
    logic [SECONDS_W-1:0]       conv_reg;

    // result register
    logic [SECONDS_W-1:0]       res_seconds_reg;
    logic [FRAC_BITS-1:0]       res_fraction_reg;
    logic [COMPARE_W-1:0]       res_compare_reg;
    logic [TIME_W-1:0]          res_tod_reg;
    logic [SECONDS_W-1:0]       res_conv_reg;
    logic                       res_time_set_reg;

    logic [SECS_W-1:0]          secs_new;
    logic [SECONDS_W-1:0]       wrap_next;
    logic [SECONDS_W-1:0]       boot_seconds_next;
    logic [TIME_W-1:0]          boot_time;
    logic [TIME_W-1:0]          wall_time;
    logic [TIME_W-1:0]          wall_diff;
    logic [SECONDS_W-1:0]       conv_next;
    logic [MATCH_W-1:0]         match_init;
    logic [TICK_W:0]            trial;
    logic [TICK_W-1:0]          rem_next;
    logic [SECONDS_W-1:0]       wake_gap;
    logic [HIB_W-1:0]           hib_step;
    logic [MATCH_W-1:0]         match_rounded;
    logic [COUNTER_BITS-1:0]    compare_next;

    assign status.sample = (cmd_reg == CMD_SAMPLE);

    always_comb
    begin
        secs_new = cntr_reg[COUNTER_BITS-1:CPS_LOG2];
        // a drop in whole seconds means the counter wrapped
        wrap_next = (secs_new < last_secs_reg) ? wrap_count_reg + 1'b1 : wrap_count_reg;
        boot_seconds_next = {wrap_next[SECONDS_W-SECS_W-1:0], secs_new};

        boot_time = {boot_seconds_reg, boot_fraction_reg, {TIME_PAD_W{1'b0}}};
        wall_time = {wall_reg, {(TIME_W-SECONDS_W){1'b0}}};
        wall_diff = wall_time - offset_reg;
        if (wall_time >= offset_reg)
        begin
            conv_next = wall_diff[TIME_W-1:SECONDS_W];
        end
        else
        begin
            conv_next = (wall_reg != '0) ? SECONDS_W'(1) : '0;
        end

        match_init = MATCH_W'(cntr_reg) + MATCH_W'(tick_reg);

        // one restoring remainder step per cycle
        trial = {rem_reg, shift_reg[MATCH_W-1]};
        if (trial >= {1'b0, tick_reg})
        begin
            rem_next = TICK_W'(trial - {1'b0, tick_reg});
        end
        else
        begin
            rem_next = trial[TICK_W-1:0];
        end

        wake_gap = wake_target_reg - boot_seconds_reg;
        hib_step = (wake_gap > SECONDS_W'(hib_max_reg)) ? hib_max_reg : wake_gap[HIB_W-1:0];
        match_rounded = match_reg - MATCH_W'(rem_reg);

        if (wake_target_reg > boot_seconds_reg)
        begin
            compare_next = cntr_reg + COUNTER_BITS'(SECONDS_W'(hib_step) << CPS_LOG2);
        end
        else if (tick_reg == '0)
        begin
            compare_next = cntr_reg;
        end
        else
        begin
            compare_next = match_rounded[COUNTER_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg          <= TICK_RESET;
            hib_max_reg       <= HIB_MAX_RESET;
            wrap_count_reg    <= '0;
            last_secs_reg     <= '0;
            boot_seconds_reg  <= '0;
            boot_fraction_reg <= '0;
            offset_reg        <= OFFSET_RESET;
            wake_target_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TICK_INCREMENT: tick_reg    <= cfg_data[TICK_W-1:0];
                    CFG_HIBERNATE_MAX:  hib_max_reg <= cfg_data[HIB_W-1:0];
                    default:            tick_reg    <= tick_reg;
                endcase
            end
            if (cmd.exec)
            begin
                unique case (cmd_reg)
                    CMD_SAMPLE:
                    begin
                        wrap_count_reg    <= wrap_next;
                        last_secs_reg     <= secs_new;
                        boot_seconds_reg  <= boot_seconds_next;
                        boot_fraction_reg <= cntr_reg[CPS_LOG2-1:FRAC_LSB];
                    end
                    CMD_SET_TIME:
                    begin
                        offset_reg <= new_time_reg - boot_time;
                    end
                    CMD_HIBERNATE:
                    begin
                        // zero cancels, otherwise only a later target is taken
                        if ((wake_at_reg == '0) || (wake_at_reg > wake_target_reg))
                        begin
                            wake_target_reg <= wake_at_reg;
                        end
                    end
                    default:
                    begin
                        wake_target_reg <= wake_target_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg      <= cmd_t'(command);
            cntr_reg     <= counter[COUNTER_BITS-1:0];
            new_time_reg <= new_time;
            wake_at_reg  <= wake_at;
            wall_reg     <= wall_seconds;
        end
        if (cmd.exec)
        begin
            match_reg   <= match_init;
            shift_reg   <= match_init;
            rem_reg     <= '0;
            compare_reg <= '0;
            conv_reg    <= (cmd_reg == CMD_CONVERT) ? conv_next : '0;
        end
        if (cmd.div_step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[MATCH_W-2:0], 1'b0};
        end
        if (cmd.compare)
        begin
            compare_reg <= compare_next;
        end
        if (cmd.publish)
        begin
            res_seconds_reg  <= boot_seconds_reg;
            res_fraction_reg <= boot_fraction_reg;
            res_compare_reg  <= COMPARE_W'(compare_reg);
            res_tod_reg      <= boot_time + offset_reg;
            res_conv_reg     <= conv_reg;
            res_time_set_reg <= (offset_reg != '0);
        end
    end

    assign seconds_since_boot = res_seconds_reg;
    assign second_fraction    = res_fraction_reg;
    assign compare_value      = res_compare_reg;
    assign time_of_day        = res_tod_reg;
    assign converted_seconds  = res_conv_reg;
    assign time_set           = res_time_set_reg;

endmodule

// ===== hdl/rtc_time_of_day_keeper.sv =====
// ----------------------------------------------------------------------------
// rtc time-of-day keeper
// extends a wrapping rtc count into boot seconds and wall time, and programs
// the next rtc compare value
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid / in_stall carry one command word (command,
//   counter, new_time, wake_at, wall_seconds); a word is taken when in_valid
//   is high and in_stall low. one word is in work at a time.
//   output channel: out_valid / out_stall carry exactly one result word per
//   input word, held stable while out_stall is high.
//   configuration: cfg_we with cfg_index and cfg_data writes tick_increment
//   (index 0) or the hibernation step limit (index 1); the user must write
//   only while idle, and the block itself does not enforce this.
//   sequence: a counter sample runs execute, the restoring remainder loop
//   over the 25-bit match value (one bit per cycle), compare and publish;
//   other commands go from execute straight to publish.
//   a finished result waits in the output register, so the next word can be
//   taken while it is stalled; a second result waits inside until the first
//   leaves.
//   reset: asynchronous, active low; time state clears, the wall offset
//   returns to eight hours, registers return to 2048 and 256.
// ----------------------------------------------------------------------------
module rtc_time_of_day_keeper
    import rtc_tod_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CMD_W-1:0]           command,
    input  logic [COUNTER_FIELD_W-1:0] counter,
    input  logic [TIME_W-1:0]          new_time,
    input  logic [SECONDS_W-1:0]       wake_at,
    input  logic [SECONDS_W-1:0]       wall_seconds,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [SECONDS_W-1:0]       seconds_since_boot,
    output logic [FRAC_BITS-1:0]       second_fraction,
    output logic [COMPARE_W-1:0]       compare_value,
    output logic [TIME_W-1:0]          time_of_day,
    output logic [SECONDS_W-1:0]       converted_seconds,
    output logic                       time_set
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    rtc_tod_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    rtc_tod_datapath u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (dp_cmd),
        .status             (dp_status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .command            (command),
        .counter            (counter),
        .new_time           (new_time),
        .wake_at            (wake_at),
        .wall_seconds       (wall_seconds),
        .seconds_since_boot (seconds_since_boot),
        .second_fraction    (second_fraction),
        .compare_value      (compare_value),
        .time_of_day        (time_of_day),
        .converted_seconds  (converted_seconds),
        .time_set           (time_set)
    );

endmodule

// ===== verif/rtc_time_of_day_keeper_check.sv =====
// ----------------------------------------------------------------------------
// rtc time-of-day keeper checker
// watches the register port and both word channels, keeps its own copy of the
// time-keeping state, predicts one result word per accepted input word and
// compares each delivered word field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtc_time_of_day_keeper_check
    import rtc_tod_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [CMD_W-1:0]           command,
    input  logic [COUNTER_FIELD_W-1:0] counter,
    input  logic [TIME_W-1:0]          new_time,
    input  logic [SECONDS_W-1:0]       wake_at,
    input  logic [SECONDS_W-1:0]       wall_seconds,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [SECONDS_W-1:0]       seconds_since_boot,
    input  logic [FRAC_BITS-1:0]       second_fraction,
    input  logic [COMPARE_W-1:0]       compare_value,
    input  logic [TIME_W-1:0]          time_of_day,
    input  logic [SECONDS_W-1:0]       converted_seconds,
    input  logic                       time_set,
    output int                         failures,
    output int                         pending
);

    typedef struct packed {
        logic [SECONDS_W-1:0] secs;
        logic [FRAC_BITS-1:0] frac;
        logic [COMPARE_W-1:0] cmp;
        logic [TIME_W-1:0]    tod;
        logic [SECONDS_W-1:0] conv;
        logic                 is_set;
    } tod_word_t;

    logic [TICK_W-1:0]    tick_inc;
    logic [HIB_W-1:0]     hib_max;
    logic [31:0]          wraps;
    logic [SECS_W-1:0]    last_secs;
    logic [SECONDS_W-1:0] boot_secs;
    logic [FRAC_BITS-1:0] boot_frac;
    logic [TIME_W-1:0]    wall_offset;
    logic [SECONDS_W-1:0] wake_tgt;

    tod_word_t expected_words[$];

    function automatic tod_word_t keep_time(cmd_t cmd, logic [COUNTER_FIELD_W-1:0] cnt,
                                            logic [TIME_W-1:0] nt, logic [31:0] wk,
                                            logic [31:0] ws);
        tod_word_t  r;
        logic [31:0] m;
        logic [31:0] dly;
        logic [SECS_W-1:0] s;
        logic [TIME_W-1:0] w64;
        logic [TIME_W-1:0] diff;
        r = '0;
        case (cmd)
            CMD_SAMPLE:
            begin
                s = cnt[COUNTER_BITS-1:CPS_LOG2];
                // whole-second part went backwards, so the rtc counter wrapped
                if (s < last_secs)
                    wraps = wraps + 1;
                last_secs = s;
                boot_secs = (wraps << SECS_W) + 32'(s);
                boot_frac = cnt[CPS_LOG2-1:FRAC_LSB];
                if (wake_tgt <= boot_secs)
                begin
                    m = 32'(cnt) + 32'(tick_inc);
                    if (tick_inc != '0)
                        m = m - (m % 32'(tick_inc));
                    else
                        m = 32'(cnt);
                end
                else
                begin
                    dly = wake_tgt - boot_secs;
                    if (dly > 32'(hib_max))
                        dly = 32'(hib_max);
                    m = 32'(cnt) + dly * 32'(COUNTS_PER_SECOND);
                end
                r.cmp = m[COMPARE_W-1:0];
            end
            CMD_SET_TIME:
                wall_offset = nt - {boot_secs, boot_frac, 24'd0};
            CMD_HIBERNATE:
            begin
                if (wk == '0 || wk > wake_tgt)
                    wake_tgt = wk;
            end
            default:
            begin
                w64 = {ws, 32'd0};
                diff = w64 - wall_offset;
                if (w64 >= wall_offset)
                    r.conv = diff[63:32];
                else
                    r.conv = (ws != '0) ? 32'd1 : 32'd0;
            end
        endcase
        r.secs   = boot_secs;
        r.frac   = boot_frac;
        r.tod    = {boot_secs, boot_frac, 24'd0} + wall_offset;
        r.is_set = (wall_offset != '0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tod_word_t want;
        if (!rst_n)
        begin
            tick_inc    = TICK_RESET;
            hib_max     = HIB_MAX_RESET;
            wraps       = '0;
            last_secs   = '0;
            boot_secs   = '0;
            boot_frac   = '0;
            wall_offset = OFFSET_RESET;
            wake_tgt    = '0;
            failures    = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TICK_INCREMENT: tick_inc = cfg_data[TICK_W-1:0];
                    CFG_HIBERNATE_MAX:  hib_max  = cfg_data[HIB_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_words.push_back(keep_time(cmd_t'(command), counter, new_time,
                                                   wake_at, wall_seconds));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("word with nothing expected", 64'(seconds_since_boot), '0);
                else
                begin
                    want = expected_words.pop_front();
                    if (seconds_since_boot !== want.secs)
                        report_mismatch("seconds_since_boot", 64'(seconds_since_boot),
                                        64'(want.secs));
                    if (second_fraction !== want.frac)
                        report_mismatch("second_fraction", 64'(second_fraction), 64'(want.frac));
                    if (compare_value !== want.cmp)
                        report_mismatch("compare_value", 64'(compare_value), 64'(want.cmp));
                    if (time_of_day !== want.tod)
                        report_mismatch("time_of_day", time_of_day, want.tod);
                    if (converted_seconds !== want.conv)
                        report_mismatch("converted_seconds", 64'(converted_seconds),
                                        64'(want.conv));
                    if (time_set !== want.is_set)
                        report_mismatch("time_set", 64'(time_set), 64'(want.is_set));
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

// ===== verif/rtc_time_of_day_keeper_test.sv =====
// ----------------------------------------------------------------------------
// rtc time-of-day keeper testbench
// directed words for counter wraps, hibernation steps, wall-time offsets and
// conversions, then mostly rising counter sequences with random commands
// mixed in, across several register settings, with random gaps and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtc_time_of_day_keeper_test;
    import rtc_tod_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    // an item needs at most a random input gap, its work and a random output stall; the long hold-off dominates
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 54;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [CMD_W-1:0]           command;
    logic [COUNTER_FIELD_W-1:0] counter;
    logic [TIME_W-1:0]          new_time;
    logic [SECONDS_W-1:0]       wake_at;
    logic [SECONDS_W-1:0]       wall_seconds;
    logic                       out_valid;
    logic                       out_stall;
    logic [SECONDS_W-1:0]       seconds_since_boot;
    logic [FRAC_BITS-1:0]       second_fraction;
    logic [COMPARE_W-1:0]       compare_value;
    logic [TIME_W-1:0]          time_of_day;
    logic [SECONDS_W-1:0]       converted_seconds;
    logic                       time_set;
    int                         failures;
    int                         pending;

    bit                         idling;
    bit                         hold_req;
    int                         idle_cycles;

    // rough view of the block's time, used only to aim the stimulus
    logic [31:0]                est_wraps;
    logic [SECS_W-1:0]          est_last_secs;
    logic [FRAC_BITS-1:0]       est_frac;
    logic [31:0]                boot_est;
    logic [31:0]                offset_secs_est;
    logic [COUNTER_FIELD_W-1:0] rtc_now;

    rtc_time_of_day_keeper dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .counter            (counter),
        .new_time           (new_time),
        .wake_at            (wake_at),
        .wall_seconds       (wall_seconds),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .seconds_since_boot (seconds_since_boot),
        .second_fraction    (second_fraction),
        .compare_value      (compare_value),
        .time_of_day        (time_of_day),
        .converted_seconds  (converted_seconds),
        .time_set           (time_set)
    );

    rtc_time_of_day_keeper_check tod_check
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .counter            (counter),
        .new_time           (new_time),
        .wake_at            (wake_at),
        .wall_seconds       (wall_seconds),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .seconds_since_boot (seconds_since_boot),
        .second_fraction    (second_fraction),
        .compare_value      (compare_value),
        .time_of_day        (time_of_day),
        .converted_seconds  (converted_seconds),
        .time_set           (time_set),
        .failures           (failures),
        .pending            (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: random stall bursts, calm stretches, and the long hold-off
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (n = 1; n < HOLD_OFF_CYCLES; n++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_word(input cmd_t c, input logic [COUNTER_FIELD_W-1:0] cnt,
                             input logic [TIME_W-1:0] nt, input logic [31:0] wk,
                             input logic [31:0] ws);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clk);
        end
        @(negedge clk);
        command      <= c;
        counter      <= cnt;
        new_time     <= nt;
        wake_at      <= wk;
        wall_seconds <= ws;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == CMD_SAMPLE)
        begin
            if (cnt[COUNTER_BITS-1:CPS_LOG2] < est_last_secs)
                est_wraps = est_wraps + 1;
            est_last_secs = cnt[COUNTER_BITS-1:CPS_LOG2];
            est_frac      = cnt[CPS_LOG2-1:FRAC_LSB];
            boot_est      = (est_wraps << SECS_W) + 32'(est_last_secs);
        end
        if (c == CMD_SET_TIME)
            offset_secs_est = nt[63:32] - boot_est;
    endtask

    // registers change only with nothing in flight
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        cmd_t                       c;
        logic [COUNTER_FIELD_W-1:0] cnt;
        logic [TIME_W-1:0]          nt;
        logic [31:0]                wk;
        logic [31:0]                ws;
        logic [CFG_DATA_W-1:0]      tick_v;
        logic [CFG_DATA_W-1:0]      hib_v;
        int                         p;
        int                         i;
        int                         pick;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        command         = '0;
        counter         = '0;
        new_time        = '0;
        wake_at         = '0;
        wall_seconds    = '0;
        idling          = 1'b1;
        hold_req        = 1'b0;
        idle_cycles     = 0;
        est_wraps       = '0;
        est_last_secs   = '0;
        est_frac        = '0;
        boot_est        = '0;
        offset_secs_est = 32'(EIGHT_HOURS_SECS);
        rtc_now         = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // conversions against the eight hour offset: below, at and far above it
        send_word(CMD_CONVERT, '0, '0, '0, '0);
        send_word(CMD_CONVERT, '1, '1, '1, 32'd1);
        send_word(CMD_CONVERT, '0, '0, '0, 32'(EIGHT_HOURS_SECS));
        send_word(CMD_CONVERT, '0, '0, '0, '1);
        // counter extremes, then a wrap
        send_word(CMD_SAMPLE, '0, '0, '0, '0);
        send_word(CMD_SAMPLE, '1, '0, '0, '0);
        send_word(CMD_SAMPLE, 24'h000100, '0, '0, '0);
        // hibernation: short step, ignored earlier target, clamped step, cancel
        send_word(CMD_HIBERNATE, '0, '0, 32'd600, '0);
        send_word(CMD_SAMPLE, 24'h010000, '0, '0, '0);
        send_word(CMD_HIBERNATE, '0, '0, 32'd100, '0);
        send_word(CMD_SAMPLE, 24'h018000, '0, '0, '0);
        send_word(CMD_HIBERNATE, '0, '0, '1, '0);
        send_word(CMD_SAMPLE, 24'h020000, '0, '0, '0);
        send_word(CMD_HIBERNATE, '0, '0, '0, '0);
        send_word(CMD_SAMPLE, 24'h030040, '0, '0, '0);
        // wall time equal to boot time leaves a zero offset
        send_word(CMD_SET_TIME, '0, {boot_est, est_frac, 24'd0}, '0, '0);
        send_word(CMD_CONVERT, '0, '0, '0, '0);
        send_word(CMD_CONVERT, '0, '0, '0, 32'd12345);
        send_word(CMD_SET_TIME, '0, '1, '0, '0);
        send_word(CMD_CONVERT, '0, '0, '0, '0);
        send_word(CMD_CONVERT, '0, '0, '0, 32'd5);
        send_word(CMD_SET_TIME, '0, 64'h5F00_0000_8000_0000, '0, '0);
        send_word(CMD_SAMPLE, 24'h7FFFFF, '0, '0, '0);
        rtc_now = 24'h7FFFFF;

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin tick_v = 16'd1;     hib_v = 16'd0;   end
                1: begin tick_v = 16'd32768; hib_v = 16'd1;   end
                2: begin tick_v = 16'd0;     hib_v = 16'd511; end
                3: begin tick_v = 16'hFFFF;  hib_v = 16'd256; end
                4: begin tick_v = 16'd3;     hib_v = 16'd2;   end
                default:
                begin
                    tick_v = 16'($urandom_range(1, 32768));
                    hib_v  = 16'($urandom);
                end
            endcase
            write_register(CFG_TICK_INCREMENT, tick_v);
            write_register(CFG_HIBERNATE_MAX, hib_v);
            // no idling in the last stretch of the run
            if (p == PHASES - 1)
                idling = 1'b0;
            for (i = 0; i < WORDS_PER_PHASE; i++)
            begin
                if (p == 1 && i == 10)
                    hold_req = 1'b1;
                if (p == 3 && i == 20)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    wait (pending == 0);
                end
                cnt  = 24'($urandom);
                nt   = {$urandom, $urandom};
                wk   = $urandom;
                ws   = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // well-formed: the rtc keeps counting forward
                    c = CMD_SAMPLE;
                    case ($urandom_range(0, 9))
                        0:       rtc_now = rtc_now + 24'($urandom);
                        1, 2, 3: rtc_now = rtc_now + 24'($urandom_range(0, 1 << 20));
                        default: rtc_now = rtc_now + 24'($urandom_range(0, 4096));
                    endcase
                    cnt = rtc_now;
                end
                else if (pick < 62)
                begin
                    c = CMD_SAMPLE;
                    rtc_now = cnt;
                end
                else if (pick < 74)
                begin
                    c = CMD_HIBERNATE;
                    case ($urandom_range(0, 4))
                        0:       wk = '0;
                        1:       ;
                        2:       wk = boot_est + $urandom_range(0, 3);
                        default: wk = boot_est + $urandom_range(1, 700);
                    endcase
                end
                else if (pick < 84)
                begin
                    c = CMD_SET_TIME;
                    case ($urandom_range(0, 3))
                        0:       nt = {boot_est, est_frac, 24'd0};
                        1:       nt[63:32] = boot_est + $urandom_range(0, 1 << 20);
                        default: ;
                    endcase
                end
                else
                begin
                    c = CMD_CONVERT;
                    case ($urandom_range(0, 3))
                        0:       ws = $urandom_range(0, 2);
                        1, 2:    ws = offset_secs_est + $urandom_range(0, 4) - 2;
                        default: ;
                    endcase
                end
                send_word(c, cnt, nt, wk, ws);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
